@@ design/imhq_pkg.sv @@
// Package for the indexed min-heap queue.
// Holds sizes, operation and status codes used by the design, its checker and the testbench.
package imhq_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdW      = 6;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned StW      = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHANGE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;
endpackage

@@ design/imhq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module imhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/indexed_min_heap_queue.sv @@
// Indexed binary min-heap priority queue, top level with the sift sequencer.
// Depends on imhq_pkg and imhq_ram.
//
// Usage: drive operation_i, element_i and priority_value_i and raise start;
// the item is taken at a rising edge where start is high and busy is low.
// Operations are insert, remove minimum and change priority; code three
// only reports the current state. Exactly one result beat follows each item,
// shown for one cycle with done_o high; the receiver cannot stall it.
// A rejected or trivial item goes straight to S_FIN. A sift climbs a level
// per pass through S_UP_RD, S_UP_PID and S_UP_CMP and descends one per pass
// through S_DN_RDL to S_DN_CMP, since each level reads the heap memory and
// then the priority memory through one read port each.
// busy stays high from acceptance through the result beat.
// Reset clears the count and the presence bits; the memories need no clearing
// because only live positions and present ids are ever read.
module indexed_min_heap_queue
  import imhq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation_i,
  input  logic [IdW-1:0]         element_i,
  input  logic signed [KeyW-1:0] priority_value_i,
  output logic                   done_o,
  output logic [IdW-1:0]         removed_element_o,
  output logic [StW-1:0]         status_o,
  output logic [IdW-1:0]         min_element_o,
  output logic                   min_valid_o,
  output logic [CntW-1:0]        element_count_o
);
  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_CH_POS  = 15'b000000000000010,
    S_RM_LAST = 15'b000000000000100,
    S_RM_KEY  = 15'b000000000001000,
    S_RM_SET  = 15'b000000000010000,
    S_UP_RD   = 15'b000000000100000,
    S_UP_PID  = 15'b000000001000000,
    S_UP_CMP  = 15'b000000010000000,
    S_DN_RDL  = 15'b000000100000000,
    S_DN_RDR  = 15'b000001000000000,
    S_DN_PL   = 15'b000010000000000,
    S_DN_PR   = 15'b000100000000000,
    S_DN_CMP  = 15'b001000000000000,
    S_PLACE   = 15'b010000000000000,
    S_FIN     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_q, out_d;

  logic [Capacity-1:0] present_q, present_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdW-1:0]      pos_q, pos_d, cur_q, cur_d, pid_q, pid_d;
  logic [IdW-1:0]      lid_q, lid_d, rid_q, rid_d, removed_q, removed_d;
  logic [KeyW-1:0]     key_q, key_d, lkey_q, lkey_d;
  logic [StW-1:0]      status_q, status_d;
  logic                chg_q, chg_d;

  logic            heap_we, slot_we, prio_we;
  logic [IdW-1:0]  heap_waddr, heap_wdata, heap_raddr, heap_rdata;
  logic [IdW-1:0]  slot_waddr, slot_wdata, slot_raddr, slot_rdata;
  logic [IdW-1:0]  prio_raddr;
  logic [KeyW-1:0] prio_rdata;

  logic [CntW-1:0] left, right;
  logic            right_ok, pick_right;
  logic [IdW-1:0]  best_id;
  logic [KeyW-1:0] best_key;
  logic [IdW-1:0]  par;

  assign left       = {pos_q, 1'b1};
  assign right      = left + CntW'(1);
  assign right_ok   = right < count_q;
  assign par        = (pos_q - IdW'(1)) >> 1;
  assign pick_right = right_ok && ($signed(prio_rdata) < $signed(lkey_q));
  assign best_id    = pick_right ? rid_q : lid_q;
  assign best_key   = pick_right ? prio_rdata : lkey_q;

  imhq_ram #(.Width(IdW), .Depth(Capacity)) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (heap_we),
    .waddr_i(heap_waddr),
    .wdata_i(heap_wdata),
    .raddr_i(heap_raddr),
    .rdata_o(heap_rdata)
  );

  imhq_ram #(.Width(IdW), .Depth(Capacity)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  imhq_ram #(.Width(KeyW), .Depth(Capacity)) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (prio_we),
    .waddr_i(element_i),
    .wdata_i(priority_value_i),
    .raddr_i(prio_raddr),
    .rdata_o(prio_rdata)
  );

  assign slot_raddr = element_i;

  always_comb begin
    state_d    = state_q;
    out_d      = 1'b0;
    present_d  = present_q;
    count_d    = count_q;
    pos_d      = pos_q;
    cur_d      = cur_q;
    pid_d      = pid_q;
    lid_d      = lid_q;
    rid_d      = rid_q;
    removed_d  = removed_q;
    key_d      = key_q;
    lkey_d     = lkey_q;
    status_d   = status_q;
    chg_d      = chg_q;
    heap_we    = 1'b0;
    slot_we    = 1'b0;
    prio_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = cur_q;
    slot_waddr = cur_q;
    slot_wdata = pos_q;
    heap_raddr = '0;
    prio_raddr = heap_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (start && !busy) begin
          status_d  = ST_OK;
          removed_d = '0;
          cur_d     = element_i;
          key_d     = priority_value_i;
          chg_d     = 1'b0;
          state_d   = S_FIN;
          case (operation_i)
            OP_INSERT: begin
              if (present_q[element_i]) begin
                status_d = ST_PRESENT;
              end else if (count_q >= CntW'(Capacity)) begin
                status_d = ST_FULL;
              end else begin
                prio_we              = 1'b1;
                present_d[element_i] = 1'b1;
                pos_d                = count_q[IdW-1:0];
                count_d              = count_q + CntW'(1);
                state_d              = S_UP_RD;
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
                state_d = S_RM_LAST;
              end
            end
            OP_CHANGE: begin
              if (!present_q[element_i]) begin
                status_d = ST_ABSENT;
              end else begin
                prio_we = 1'b1;
                chg_d   = 1'b1;
                state_d = S_CH_POS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CH_POS: begin
        pos_d   = slot_rdata;
        state_d = S_UP_RD;
      end
      S_RM_LAST: begin
        removed_d              = heap_rdata;
        present_d[heap_rdata]  = 1'b0;
        heap_raddr             = count_q[IdW-1:0];
        state_d                = S_RM_KEY;
      end
      S_RM_KEY: begin
        cur_d   = heap_rdata;
        pos_d   = '0;
        state_d = S_RM_SET;
      end
      S_RM_SET: begin
        key_d   = prio_rdata;
        state_d = (count_q != '0) ? S_DN_RDL : S_FIN;
      end
      S_UP_RD: begin
        heap_raddr = par;
        if (pos_q == '0) begin
          state_d = chg_q ? S_DN_RDL : S_PLACE;
        end else begin
          state_d = S_UP_PID;
        end
      end
      S_UP_PID: begin
        pid_d   = heap_rdata;
        state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        if ($signed(key_q) < $signed(prio_rdata)) begin
          heap_we    = 1'b1;
          heap_wdata = pid_q;
          slot_we    = 1'b1;
          slot_waddr = pid_q;
          pos_d      = par;
          state_d    = S_UP_RD;
        end else begin
          state_d = chg_q ? S_DN_RDL : S_PLACE;
        end
      end
      S_DN_RDL: begin
        heap_raddr = left[IdW-1:0];
        state_d    = (left >= count_q) ? S_PLACE : S_DN_RDR;
      end
      S_DN_RDR: begin
        lid_d      = heap_rdata;
        heap_raddr = right[IdW-1:0];
        state_d    = S_DN_PL;
      end
      S_DN_PL: begin
        rid_d      = heap_rdata;
        prio_raddr = lid_q;
        state_d    = S_DN_PR;
      end
      S_DN_PR: begin
        lkey_d     = prio_rdata;
        prio_raddr = rid_q;
        state_d    = S_DN_CMP;
      end
      S_DN_CMP: begin
        if ($signed(best_key) < $signed(key_q)) begin
          heap_we    = 1'b1;
          heap_wdata = best_id;
          slot_we    = 1'b1;
          slot_waddr = best_id;
          pos_d      = pick_right ? right[IdW-1:0] : left[IdW-1:0];
          state_d    = S_DN_RDL;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        out_d   = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_q     <= 1'b0;
      present_q <= '0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      out_q     <= out_d;
      present_q <= present_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    pid_q     <= pid_d;
    lid_q     <= lid_d;
    rid_q     <= rid_d;
    removed_q <= removed_d;
    key_q     <= key_d;
    lkey_q    <= lkey_d;
    status_q  <= status_d;
    chg_q     <= chg_d;
  end

  assign busy              = (state_q != S_IDLE) || out_q;
  assign done_o            = out_q;
  assign removed_element_o = removed_q;
  assign status_o          = status_q;
  assign min_valid_o       = count_q != '0;
  assign min_element_o     = min_valid_o ? heap_rdata : '0;
  assign element_count_o   = count_q;
endmodule

@@ design/imhq_checker.sv @@
// Port-level checker for the indexed min-heap queue, bound to the top level.
// Depends on imhq_pkg.
module imhq_checker
  import imhq_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic [StW-1:0]  status_o,
  input logic [IdW-1:0]  removed_element_o,
  input logic            min_valid_o,
  input logic [CntW-1:0] element_count_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (min_valid_o == (element_count_o != '0)))
    else $error("min_valid disagrees with count");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (element_count_o <= CntW'(Capacity)))
    else $error("count above capacity");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (removed_element_o == '0))
    else $error("removed id on a failed item");
endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .status_o         (status_o),
  .removed_element_o(removed_element_o),
  .min_valid_o      (min_valid_o),
  .element_count_o  (element_count_o)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the indexed min-heap queue.
// Drives heap operations, predicts each result beat with its own heap model.
// Depends on imhq_pkg and indexed_min_heap_queue.
`timescale 1ns / 100ps

module testbench
  import imhq_pkg::*;
();

  typedef struct packed {
    logic [IdW-1:0]  removed;
    logic [StW-1:0]  status;
    logic [IdW-1:0]  min_id;
    logic            min_ok;
    logic [CntW-1:0] cnt;
  } beat_t;

  typedef struct {
    op_e                   op;
    logic [IdW-1:0]        id;
    logic signed [KeyW-1:0] pri;
    logic                  typed;
    beat_t                 want;
  } row_t;

  logic clk_i, rst_ni, start, busy, done_o, min_valid_o;
  logic [1:0] operation_i;
  logic [IdW-1:0] element_i, removed_element_o, min_element_o;
  logic signed [KeyW-1:0] priority_value_i;
  logic [StW-1:0] status_o;
  logic [CntW-1:0] element_count_o;

  indexed_min_heap_queue dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .element_i, .priority_value_i,
    .done_o, .removed_element_o, .status_o, .min_element_o, .min_valid_o,
    .element_count_o
  );

  logic [IdW-1:0]  heap_ids [Capacity];
  logic [IdW-1:0]  slot_of [Capacity];
  logic            present [Capacity];
  logic signed [KeyW-1:0] prio [Capacity];
  int unsigned     live;
  beat_t           pending_beats[$];
  int              errors;
  longint          cycles;
  int              send_idle_pct;

  function automatic void swap_pos(int unsigned a, int unsigned b);
    logic [IdW-1:0] ea, eb;
    ea = heap_ids[a];
    eb = heap_ids[b];
    heap_ids[a] = eb;
    heap_ids[b] = ea;
    slot_of[eb] = IdW'(a);
    slot_of[ea] = IdW'(b);
  endfunction

  function automatic void bubble_up(logic [IdW-1:0] id);
    int unsigned pos, par;
    pos = slot_of[id];
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (prio[id] < prio[heap_ids[par]]) begin
        swap_pos(pos, par);
        pos = par;
      end else break;
    end
  endfunction

  function automatic void bubble_down(logic [IdW-1:0] id);
    int unsigned pos, lft, best;
    pos = slot_of[id];
    forever begin
      lft = 2 * pos + 1;
      if (lft >= live) break;
      best = lft;
      if (lft + 1 < live && prio[heap_ids[lft + 1]] < prio[heap_ids[lft]]) best = lft + 1;
      if (prio[heap_ids[best]] < prio[id]) begin
        swap_pos(pos, best);
        pos = best;
      end else break;
    end
  endfunction

  function automatic beat_t heap_apply(op_e op, logic [IdW-1:0] id,
                                       logic signed [KeyW-1:0] pri);
    beat_t r;
    logic [IdW-1:0] last;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (present[id]) r.status = ST_PRESENT;
        else if (live >= Capacity) r.status = ST_FULL;
        else begin
          heap_ids[live] = id;
          slot_of[id] = IdW'(live);
          prio[id] = pri;
          present[id] = 1'b1;
          live++;
          bubble_up(id);
        end
      end
      OP_REMOVE: begin
        if (live == 0) r.status = ST_EMPTY;
        else begin
          r.removed = heap_ids[0];
          last = heap_ids[live - 1];
          present[heap_ids[0]] = 1'b0;
          live--;
          if (live > 0) begin
            heap_ids[0] = last;
            slot_of[last] = '0;
            bubble_down(last);
          end
        end
      end
      OP_CHANGE: begin
        if (!present[id]) r.status = ST_ABSENT;
        else begin
          prio[id] = pri;
          bubble_up(id);
          bubble_down(id);
        end
      end
      default: ;
    endcase
    r.min_id = (live > 0) ? heap_ids[0] : '0;
    r.min_ok = (live > 0);
    r.cnt = CntW'(live);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_beat(op_e op, logic [IdW-1:0] id, logic signed [KeyW-1:0] pri,
                           logic typed, beat_t want);
    beat_t p;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    p = heap_apply(op, id, pri);
    if (typed && p != want) report_mismatch("typed row", p, want);
    pending_beats.push_back(p);
    operation_i <= op;
    element_i <= id;
    priority_value_i <= pri;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic beat_t mk(int rem, status_e st, int mn, int ok, int c);
    beat_t b;
    b.removed = IdW'(rem);
    b.status = st;
    b.min_id = IdW'(mn);
    b.min_ok = ok[0];
    b.cnt = CntW'(c);
    return b;
  endfunction

  always @(posedge clk_i) begin
    beat_t w;
    if (rst_ni && done_o) begin
      if (pending_beats.size() == 0) report_mismatch("unexpected beat", 1, 0);
      else begin
        w = pending_beats.pop_front();
        if (removed_element_o !== w.removed)
          report_mismatch("removed_element", removed_element_o, w.removed);
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (min_element_o !== w.min_id)
          report_mismatch("min_element", min_element_o, w.min_id);
        if (min_valid_o !== w.min_ok) report_mismatch("min_valid", min_valid_o, w.min_ok);
        if (element_count_o !== w.cnt)
          report_mismatch("element_count", element_count_o, w.cnt);
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    logic [IdW-1:0] id;
    logic signed [KeyW-1:0] pri;
    int unsigned k;
    op_e op;
    errors = 0;
    cycles = 0;
    live = 0;
    send_idle_pct = 0;
    foreach (present[i]) present[i] = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OP_NOP;
    element_i = '0;
    priority_value_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{OP_NOP, 6'd0, 0, 1, mk(0, ST_OK, 0, 0, 0)});
    rows.push_back('{OP_REMOVE, 6'd0, 0, 1, mk(0, ST_EMPTY, 0, 0, 0)});
    rows.push_back('{OP_CHANGE, 6'd5, 0, 1, mk(0, ST_ABSENT, 0, 0, 0)});
    rows.push_back('{OP_INSERT, 6'd63, 32'sh7fffffff, 1, mk(0, ST_OK, 63, 1, 1)});
    rows.push_back('{OP_INSERT, 6'd63, 0, 1, mk(0, ST_PRESENT, 63, 1, 1)});
    rows.push_back('{OP_INSERT, 6'd0, 32'sh80000000, 1, mk(0, ST_OK, 0, 1, 2)});
    rows.push_back('{OP_INSERT, 6'd7, 32'sh80000000, 0, '0});
    rows.push_back('{OP_INSERT, 6'd9, 32'sh0, 0, '0});
    rows.push_back('{OP_INSERT, 6'd42, -1, 0, '0});
    rows.push_back('{OP_CHANGE, 6'd63, 32'sh80000000, 0, '0});
    rows.push_back('{OP_CHANGE, 6'd0, 32'sh7fffffff, 0, '0});
    rows.push_back('{OP_NOP, 6'd21, 32'sh5555aaaa, 0, '0});
    for (int i = 0; i < 6; i++) rows.push_back('{OP_REMOVE, 6'd0, 0, 0, '0});
    rows.push_back('{OP_REMOVE, 6'd0, 0, 1, mk(0, ST_EMPTY, 0, 0, 0)});
    foreach (rows[i]) send_beat(rows[i].op, rows[i].id, rows[i].pri, rows[i].typed,
                                rows[i].want);

    // Fill to capacity, insert a present id once more, then drain; every beat predicted.
    for (int i = 0; i < Capacity; i++) send_beat(OP_INSERT, IdW'(i), $urandom, 0, '0);
    send_beat(OP_INSERT, 6'd3, 0, 0, '0);
    while (pending_beats.size() != 0) @(posedge clk_i);
    for (int i = 0; i < Capacity; i++) send_beat(OP_REMOVE, '0, 0, 0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : ((phase == 1) ? 56 : 0);
      for (int n = 0; n < 250; n++) begin
        k = $urandom_range(99);
        id = (live > 40) ? IdW'($urandom_range(63))
                         : IdW'($urandom_range(15) + 16 * (phase % 4));
        if ($urandom_range(3) == 0) pri = $urandom;
        else pri = $signed($urandom_range(64)) - 32;
        if (k < 45) op = OP_INSERT;
        else if (k < 75) op = OP_REMOVE;
        else if (k < 96) op = OP_CHANGE;
        else op = OP_NOP;
        if (op == OP_CHANGE && live > 0 && $urandom_range(3) != 0)
          id = heap_ids[$urandom_range(live - 1)];
        send_beat(op, id, pri, 0, '0);
      end
    end

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
